// ----- sv/rational_arith_gcd_reduce_assert.svh -----
// Assertion helpers for the rational reduction block
`ifndef RATIONAL_ARITH_GCD_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_GCD_REDUCE_ASSERT_SVH

// Check a consequence in the same cycle
`define RAG_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rag: same-cycle check failed");

// Check a consequence in the next cycle
`define RAG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rag: next-cycle check failed");

`endif

// ----- sv/rag_pkg.sv -----
`default_nettype none
package rag_pkg;
   localparam int DATA_W = 32;
   localparam int DEN_W  = 31;
   localparam int FUNC_W = 2;
   localparam int STAT_W = 2;

   typedef logic [FUNC_W-1:0] func_type;
   typedef logic [STAT_W-1:0] stat_type;

   localparam func_type FUNC_ADD = 2'd0;
   localparam func_type FUNC_SUB = 2'd1;
   localparam func_type FUNC_MUL = 2'd2;
   localparam func_type FUNC_DIV = 2'd3;

   localparam stat_type STAT_OK       = 2'd0;
   localparam stat_type STAT_ZERO_DEN = 2'd1;
   localparam stat_type STAT_OVERFLOW = 2'd2;
endpackage
`default_nettype wire

// ----- sv/rag_req_if.sv -----
`default_nettype none
interface rag_req_if;
   import rag_pkg::*;
   logic                     valid;
   logic                     ready;
   func_type                 func;
   logic signed [DATA_W-1:0] left_numer;
   logic signed [DATA_W-1:0] left_denom;
   logic signed [DATA_W-1:0] right_numer;
   logic signed [DATA_W-1:0] right_denom;

   modport source (output valid, func, left_numer, left_denom, right_numer, right_denom,
                   input ready);
   modport sink (input valid, func, left_numer, left_denom, right_numer, right_denom,
                 output ready);
endinterface
`default_nettype wire

// ----- sv/rag_rsp_if.sv -----
`default_nettype none
interface rag_rsp_if;
   import rag_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_numer;
   logic [DEN_W-1:0]         result_denom;
   stat_type                 status;

   modport source (output valid, result_numer, result_denom, status, input ready);
   modport sink (input valid, result_numer, result_denom, status, output ready);
endinterface
`default_nettype wire

// ----- sv/rag_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle
module rag_div #(
   parameter int M = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [M-1:0] dividend,
   input  wire logic [M-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [M-1:0]      quotient
);
   localparam int CW = $clog2(M + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [M:0]    rem_ff, rem_in;
   logic [M-1:0]  quo_ff, quo_in;
   logic [M-1:0]  dsr_ff, dsr_in;
   logic [M:0]    trial;
   logic          fit;

   assign trial = {rem_ff[M-1:0], quo_ff[M-1]};
   assign fit   = trial >= {1'b0, dsr_ff};

   // Load on start, then shift and subtract
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         cnt_in  = CW'(M);
         busy_in = 1'b1;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fit ? (trial - {1'b0, dsr_ff}) : trial;
         quo_in = {quo_ff[M-2:0], fit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ----- sv/rational_arith_gcd_reduce.sv -----
// Rational add, subtract, multiply and divide with reduction to lowest terms. One item
// is taken at a time: three products go through one shared WIDTH x WIDTH multiplier,
// a binary gcd on 2*WIDTH-bit magnitudes shifts or subtracts once a cycle, and a
// restoring divider performs each of the two divisions by the gcd, plus one more
// division when the result saturates. A zero denominator or a zero result skips the
// gcd and the divisions. The result sits in an output register, and the next item is
// taken once it has been loaded there.
`default_nettype none
module rational_arith_gcd_reduce #(
   parameter int WIDTH = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   rag_req_if.sink   req_chan,
   rag_rsp_if.source rsp_chan
);
   import rag_pkg::*;

   localparam int M  = 2 * WIDTH;
   localparam int KW = $clog2(M + 1);
   localparam logic [M-1:0] LIM_POS = M'((64'd1 << (WIDTH - 1)) - 64'd1);
   localparam logic [M-1:0] LIM_NEG = M'(64'd1 << (WIDTH - 1));

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_P0   = 4'd1;
   localparam logic [3:0] S_P1   = 4'd2;
   localparam logic [3:0] S_P2   = 4'd3;
   localparam logic [3:0] S_SUM  = 4'd4;
   localparam logic [3:0] S_TWOS = 4'd5;
   localparam logic [3:0] S_GCD  = 4'd6;
   localparam logic [3:0] S_DIVN = 4'd7;
   localparam logic [3:0] S_DIVQ = 4'd8;
   localparam logic [3:0] S_CHK  = 4'd9;
   localparam logic [3:0] S_SAT  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   logic [3:0]  state_ff, state_in;
   func_type    func_ff, func_in;
   logic [WIDTH-1:0] am_ff, am_in, bm_ff, bm_in, cm_ff, cm_in, dm_ff, dm_in;
   logic        an_ff, an_in, bn_ff, bn_in, cn_ff, cn_in, dn_ff, dn_in;
   logic [M-1:0] prod_ff, prod_in, p0_ff, p0_in, p1_ff, p1_in;
   logic [M-1:0] u_ff, u_in, v_ff, v_in, g_ff, g_in, n_ff, n_in;
   logic [M-1:0] den_keep_ff, den_keep_in;
   logic [KW-1:0] k_ff, k_in;
   logic        neg_ff, neg_in;
   logic signed [WIDTH-1:0] rnum_ff, rnum_in;
   logic [WIDTH-2:0] rden_ff, rden_in;
   stat_type    rst_ff, rst_in;
   logic        ovalid_ff, ovalid_in;
   logic signed [DATA_W-1:0] onum_ff, onum_in;
   logic [DEN_W-1:0] oden_ff, oden_in;
   stat_type    ostat_ff, ostat_in;

   logic [WIDTH-1:0] va, vb, vc, vd, mul_x, mul_y;
   logic        s0, s1, s2, s1e;
   logic [M-1:0] num_mag, den_mag;
   logic        num_neg, den_neg;
   logic        div_start, div_busy, div_done;
   logic [M-1:0] div_a, div_b, div_q, n_clamp;
   logic        accept;

   rag_div #(.M(M)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // Take the low WIDTH bits of each operand as sign and magnitude
   always_comb begin
      va = req_chan.left_numer[WIDTH-1:0];
      vb = req_chan.left_denom[WIDTH-1:0];
      vc = req_chan.right_numer[WIDTH-1:0];
      vd = req_chan.right_denom[WIDTH-1:0];
   end

   // Share one multiplier over the three products
   always_comb begin
      unique case (state_ff)
         S_P0:    begin mul_x = am_ff; mul_y = (func_ff == FUNC_MUL) ? cm_ff : dm_ff; end
         S_P1:    begin mul_x = bm_ff; mul_y = cm_ff; end
         default: begin mul_x = bm_ff; mul_y = dm_ff; end
      endcase
   end

   // Form the raw signed numerator and denominator
   always_comb begin
      s0  = an_ff ^ ((func_ff == FUNC_MUL) ? cn_ff : dn_ff);
      s1  = bn_ff ^ cn_ff;
      s2  = bn_ff ^ dn_ff;
      s1e = s1 ^ (func_ff == FUNC_SUB);
      num_mag = p0_ff;
      num_neg = s0;
      den_mag = prod_ff;
      den_neg = s2;
      if (func_ff == FUNC_ADD || func_ff == FUNC_SUB) begin
         if (s0 == s1e) begin
            num_mag = p0_ff + p1_ff;
         end else if (p0_ff >= p1_ff) begin
            num_mag = p0_ff - p1_ff;
         end else begin
            num_mag = p1_ff - p0_ff;
            num_neg = s1e;
         end
      end else if (func_ff == FUNC_DIV) begin
         den_mag = p1_ff;
         den_neg = s1;
      end
   end

   // Clamp a saturated quotient to the signed range
   always_comb begin
      n_clamp = div_q;
      if (neg_ff && div_q > LIM_NEG) begin
         n_clamp = LIM_NEG;
      end else if (!neg_ff && div_q > LIM_POS) begin
         n_clamp = LIM_POS;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      func_in = func_ff;
      am_in = am_ff; bm_in = bm_ff; cm_in = cm_ff; dm_in = dm_ff;
      an_in = an_ff; bn_in = bn_ff; cn_in = cn_ff; dn_in = dn_ff;
      prod_in = prod_ff; p0_in = p0_ff; p1_in = p1_ff;
      u_in = u_ff; v_in = v_ff; g_in = g_ff; n_in = n_ff; k_in = k_ff;
      neg_in = neg_ff;
      rnum_in = rnum_ff; rden_in = rden_ff; rst_in = rst_ff;
      ovalid_in = ovalid_ff && !rsp_chan.ready;
      onum_in = onum_ff; oden_in = oden_ff; ostat_in = ostat_ff;
      div_start = 1'b0;
      div_a = n_ff;
      div_b = g_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = req_chan.func;
               an_in = va[WIDTH-1]; am_in = va[WIDTH-1] ? -va : va;
               bn_in = vb[WIDTH-1]; bm_in = vb[WIDTH-1] ? -vb : vb;
               cn_in = vc[WIDTH-1]; cm_in = vc[WIDTH-1] ? -vc : vc;
               dn_in = vd[WIDTH-1]; dm_in = vd[WIDTH-1] ? -vd : vd;
               if (vb == '0 || vd == '0 || (req_chan.func == FUNC_DIV && vc == '0)) begin
                  rnum_in  = '0;
                  rden_in  = (WIDTH-1)'(1);
                  rst_in   = STAT_ZERO_DEN;
                  state_in = S_OUT;
               end else begin
                  state_in = S_P0;
               end
            end
         end
         S_P0: begin
            prod_in  = mul_x * mul_y;
            state_in = S_P1;
         end
         S_P1: begin
            p0_in    = prod_ff;
            prod_in  = mul_x * mul_y;
            state_in = S_P2;
         end
         S_P2: begin
            p1_in    = prod_ff;
            prod_in  = mul_x * mul_y;
            state_in = S_SUM;
         end
         S_SUM: begin
            neg_in = num_neg ^ den_neg;
            u_in   = num_mag;
            v_in   = den_mag;
            k_in   = '0;
            if (num_mag == '0) begin
               rnum_in  = '0;
               rden_in  = (WIDTH-1)'(1);
               rst_in   = STAT_OK;
               state_in = S_OUT;
            end else begin
               state_in = S_TWOS;
            end
         end
         S_TWOS: begin
            // drop common factors of two
            if (u_ff[0] || v_ff[0]) begin
               state_in = S_GCD;
            end else begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end
         end
         S_GCD: begin
            if (u_ff == '0) begin
               g_in     = v_ff << k_ff;
               state_in = S_DIVN;
               div_start = 1'b1;
               div_a    = num_mag;
               div_b    = v_ff << k_ff;
               n_in     = num_mag;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         S_DIVN: begin
            if (div_done) begin
               n_in      = div_q;
               div_start = 1'b1;
               div_a     = u_ff;
               div_b     = g_ff;
               state_in  = S_DIVQ;
            end
         end
         S_DIVQ: begin
            if (div_done) begin
               u_in     = div_q;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (u_ff <= LIM_POS && n_ff <= (neg_ff ? LIM_NEG : LIM_POS)) begin
               rnum_in  = neg_ff ? -n_ff[WIDTH-1:0] : n_ff[WIDTH-1:0];
               rden_in  = u_ff[WIDTH-2:0];
               rst_in   = STAT_OK;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               div_a     = n_ff;
               div_b     = u_ff;
               state_in  = S_SAT;
            end
         end
         S_SAT: begin
            if (div_done) begin
               rnum_in  = neg_ff ? -n_clamp[WIDTH-1:0] : n_clamp[WIDTH-1:0];
               rden_in  = (WIDTH-1)'(1);
               rst_in   = STAT_OVERFLOW;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!ovalid_ff || rsp_chan.ready) begin
               ovalid_in = 1'b1;
               onum_in   = DATA_W'(rnum_ff);
               oden_in   = DEN_W'(rden_ff);
               ostat_in  = rst_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // the denominator magnitude waits in u while the numerator is divided
      if (state_ff == S_GCD && u_ff == '0) begin
         u_in = den_keep_ff;
      end
   end

   // Keep the raw denominator for the second division
   assign den_keep_in = (state_ff == S_SUM) ? den_mag : den_keep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
      func_ff <= func_in;
      am_ff <= am_in; bm_ff <= bm_in; cm_ff <= cm_in; dm_ff <= dm_in;
      an_ff <= an_in; bn_ff <= bn_in; cn_ff <= cn_in; dn_ff <= dn_in;
      prod_ff <= prod_in; p0_ff <= p0_in; p1_ff <= p1_in;
      u_ff <= u_in; v_ff <= v_in; g_ff <= g_in; n_ff <= n_in; k_ff <= k_in;
      neg_ff <= neg_in;
      rnum_ff <= rnum_in; rden_ff <= rden_in; rst_ff <= rst_in;
      onum_ff <= onum_in; oden_ff <= oden_in; ostat_ff <= ostat_in;
      den_keep_ff <= den_keep_in;
   end

   assign rsp_chan.valid        = ovalid_ff;
   assign rsp_chan.result_numer = onum_ff;
   assign rsp_chan.result_denom = oden_ff;
   assign rsp_chan.status       = ostat_ff;

   `include "rational_arith_gcd_reduce_assert.svh"

   `RAG_ASSERT_NOW(a_div_free, div_start, !div_busy)
   `RAG_ASSERT_NOW(a_gcd_nonzero, state_ff == S_GCD, v_ff != '0)
   `RAG_ASSERT_NOW(a_zero_den_form, rsp_chan.valid && rsp_chan.status == STAT_ZERO_DEN,
                   rsp_chan.result_numer == '0 && rsp_chan.result_denom == DEN_W'(1))
   `RAG_ASSERT_NEXT(a_busy_after_take, accept, !req_chan.ready)
endmodule
`default_nettype wire
